// ----- sv/spfe_pkg.sv -----
package spfe_pkg;

	localparam int SAMPLE_W = 32;
	localparam int WORD_W   = 32;
	localparam int CFG_W    = 8;
	localparam int FRAME_W  = 8;
	localparam int IDX_W    = 2;
	localparam int SUB_HB   = 64;   // half-bits per subframe
	localparam int FRAME_HB = 128;  // half-bits per stereo frame

	localparam int FRAMES_PER_BLOCK_DEF = 192;

	// preambles as sent with the line low
	localparam logic [7:0] PRE_M = 8'hE2;
	localparam logic [7:0] PRE_W = 8'hE4;
	localparam logic [7:0] PRE_B = 8'hE8;

	// channel status bytes that come from registers
	localparam logic [4:0] CS_BYTE_ZERO = 5'd0;
	localparam logic [4:0] CS_BYTE_CHAN = 5'd2;
	localparam logic [4:0] CS_BYTE_RATE = 5'd3;

	// register indexes
	localparam logic [IDX_W-1:0] REG_STATUS_ZERO = 2'd0;
	localparam logic [IDX_W-1:0] REG_LEFT_CHAN   = 2'd1;
	localparam logic [IDX_W-1:0] REG_RIGHT_CHAN  = 2'd2;
	localparam logic [IDX_W-1:0] REG_RATE_CODE   = 2'd3;

	localparam logic [CFG_W-1:0] RST_STATUS_ZERO = 8'h04;
	localparam logic [CFG_W-1:0] RST_LEFT_CHAN   = 8'h10;
	localparam logic [CFG_W-1:0] RST_RIGHT_CHAN  = 8'h20;
	localparam logic [CFG_W-1:0] RST_RATE_CODE   = 8'h01;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_sample;
		logic signed [SAMPLE_W-1:0] right_sample;
	} in_beat_t;

	typedef struct packed {
		logic [WORD_W-1:0] line_word;
		logic              word_last;
	} out_beat_t;

endpackage

// ----- sv/spfe_subframe.sv -----
module spfe_subframe (
	input  logic [7:0]                     pre,
	input  logic signed [spfe_pkg::SAMPLE_W-1:0] sample,
	input  logic                           cs,
	input  logic                           level_in,
	output logic [spfe_pkg::SUB_HB-1:0]    halfbits,
	output logic                           level_out
);
	import spfe_pkg::*;

	logic [23:0] s24;
	logic [27:0] d;
	logic [7:0]  sym;
	logic [27:0] lvl;
	logic        in_range;

	// saturate to 24 bits: in range when bits 31..23 all agree
	assign in_range = (&sample[31:23]) | ~(|sample[31:23]);
	assign s24 = in_range ? sample[23:0] : (sample[31] ? 24'h800000 : 24'h7FFFFF);

	assign sym = level_in ? ~pre : pre;
	// data bits, first sent in bit 0: sample, validity, user, status, parity
	assign d   = {(^s24) ^ cs, cs, 1'b0, 1'b0, s24};

	always_comb begin
		halfbits = '0;
		halfbits[SUB_HB-1 -: 8] = sym;
		for (int i = 0; i < 28; i++) begin
			// level before bit i: each bit flips once, plus once more per 1
			lvl[i] = sym[0] ^ 1'(i) ^ (^(d & ((28'd1 << i) - 28'd1)));
			halfbits[55 - 2*i] = ~lvl[i];
			halfbits[54 - 2*i] = ~lvl[i] ^ d[i];
		end
	end

	assign level_out = sym[0] ^ (^d);

endmodule

// ----- sv/spfe_word_out.sv -----
module spfe_word_out (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic [spfe_pkg::FRAME_HB-1:0] frame,
	output logic                          free,
	output logic                          out_valid,
	input  logic                          out_stall,
	output spfe_pkg::out_beat_t           out_data
);
	import spfe_pkg::*;

	logic [FRAME_HB-1:0] frame_s2;
	logic                valid_s2;
	logic [1:0]          word_q;
	logic [1:0]          sel;
	logic                take;
	logic                last;

	assign take = valid_s2 & ~out_stall;
	assign last = (word_q == 2'd3);
	assign free = ~valid_s2 | (take & last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			word_q   <= '0;
		end else if (load) begin
			valid_s2 <= 1'b1;
			word_q   <= '0;
		end else if (take) begin
			if (last)
				valid_s2 <= 1'b0;
			word_q <= word_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			frame_s2 <= frame;
	end

	// first word sits in the top 32 bits
	assign sel                = ~word_q;
	assign out_valid          = valid_s2;
	assign out_data.line_word = frame_s2[{sel, 5'd0} +: WORD_W];
	assign out_data.word_last = last;

endmodule

// ----- sv/spdif_frame_bmc_encoder.sv -----
// S/PDIF frame encoder. Each input beat is one stereo frame (left and right
// 32-bit signed samples, saturated to 24 bits); it yields four output beats of
// 32 biphase-mark half-bits each, first half-bit in bit 31, left subframe in
// the first two beats, word_last set on the fourth. The left subframe opens
// with preamble B on frame 0 of the 192-frame block (FRAMES_PER_BLOCK) and M
// otherwise; the right opens with W. Channel status comes from bytes 0, 2
// (per channel) and 3 in the write registers, all other bytes zero; the bit
// of a frame is bit frame%8 of byte frame/8. Validity and user bits are zero,
// parity is even. Timing: an input beat is registered, encoded combinationally
// into a 128-bit frame buffer, and the buffer is shifted out one word per
// cycle while out_stall is low; the first word is offered from the buffer
// register after the frame has passed through the input register.
// The next frame is held in the input register while the buffer drains and
// moves in on the cycle the last word is taken. Frame counter and line level
// advance when a frame enters the buffer. Configuration writes take effect
// at once and are meant for idle periods; indexes are 0..3.
module spdif_frame_bmc_encoder #(
	parameter int FRAMES_PER_BLOCK = spfe_pkg::FRAMES_PER_BLOCK_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  spfe_pkg::in_beat_t          in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output spfe_pkg::out_beat_t         out_data,
	input  logic                        write_en,
	input  logic [spfe_pkg::IDX_W-1:0]  write_index,
	input  logic [spfe_pkg::CFG_W-1:0]  write_data
);
	import spfe_pkg::*;

	// config registers
	logic [CFG_W-1:0] status_zero_q;
	logic [CFG_W-1:0] left_chan_q;
	logic [CFG_W-1:0] right_chan_q;
	logic [CFG_W-1:0] rate_code_q;

	// frame state
	logic [FRAME_W-1:0] frame_q;
	logic               level_q;

	// input register
	in_beat_t in_s1;
	logic     valid_s1;

	logic                advance;
	logic                buf_free;
	logic [FRAME_HB-1:0] frame_bits;
	logic                level_mid;
	logic                level_end;
	logic [7:0]          left_pre;
	logic                left_cs;
	logic                right_cs;
	logic [CFG_W-1:0]    left_byte;
	logic [CFG_W-1:0]    right_byte;
	logic [FRAME_W:0]    frame_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_zero_q <= RST_STATUS_ZERO;
			left_chan_q   <= RST_LEFT_CHAN;
			right_chan_q  <= RST_RIGHT_CHAN;
			rate_code_q   <= RST_RATE_CODE;
		end else if (write_en) begin
			unique case (write_index)
				REG_STATUS_ZERO: status_zero_q <= write_data;
				REG_LEFT_CHAN:   left_chan_q   <= write_data;
				REG_RIGHT_CHAN:  right_chan_q  <= write_data;
				REG_RATE_CODE:   rate_code_q   <= write_data;
				default: ;
			endcase
		end
	end

	// input side stalls only while a frame waits for the buffer
	assign advance  = valid_s1 & buf_free;
	assign in_stall = valid_s1 & ~buf_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			in_s1 <= in_data;
	end

	// channel status byte select by frame / 8
	always_comb begin
		left_byte  = '0;
		right_byte = '0;
		case (frame_q[FRAME_W-1:3])
			CS_BYTE_ZERO: begin
				left_byte  = status_zero_q;
				right_byte = status_zero_q;
			end
			CS_BYTE_CHAN: begin
				left_byte  = left_chan_q;
				right_byte = right_chan_q;
			end
			CS_BYTE_RATE: begin
				left_byte  = rate_code_q;
				right_byte = rate_code_q;
			end
			default: ;
		endcase
	end

	assign left_cs  = left_byte[frame_q[2:0]];
	assign right_cs = right_byte[frame_q[2:0]];
	assign left_pre = (frame_q == '0) ? PRE_B : PRE_M;

	spfe_subframe u_left (
		.pre       (left_pre),
		.sample    (in_s1.left_sample),
		.cs        (left_cs),
		.level_in  (level_q),
		.halfbits  (frame_bits[FRAME_HB-1 -: SUB_HB]),
		.level_out (level_mid)
	);

	spfe_subframe u_right (
		.pre       (PRE_W),
		.sample    (in_s1.right_sample),
		.cs        (right_cs),
		.level_in  (level_mid),
		.halfbits  (frame_bits[SUB_HB-1:0]),
		.level_out (level_end)
	);

	assign frame_inc = {1'b0, frame_q} + {{FRAME_W{1'b0}}, 1'b1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
			level_q <= 1'b0;
		end else if (advance) begin
			level_q <= level_end;
			if (frame_inc >= (FRAME_W+1)'(FRAMES_PER_BLOCK))
				frame_q <= '0;
			else
				frame_q <= frame_inc[FRAME_W-1:0];
		end
	end

	spfe_word_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.frame     (frame_bits),
		.free      (buf_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ----- sv/spfe_checker.sv -----
module spfe_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input spfe_pkg::out_beat_t out_data
);
	import spfe_pkg::*;

	logic [1:0] word_q;
	logic [7:0] head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			word_q <= '0;
		else if (out_valid && !out_stall)
			word_q <= word_q + 2'd1;
	end

	assign head = out_data.line_word[WORD_W-1 -: 8];

	// a stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output beat changed under stall");

	// frames come as four words, marked on the fourth
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.word_last == (word_q == 2'd3))
		else $error("word_last out of step with word count");

	// words of one frame follow without a gap
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_data.word_last |=> out_valid)
		else $error("gap inside a frame");

	// first word opens with a left preamble, third with a right one
	a_left_pre: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && word_q == 2'd0 |->
			head == PRE_B || head == PRE_M || head == ~PRE_B || head == ~PRE_M)
		else $error("missing left preamble");

	a_right_pre: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && word_q == 2'd2 |-> head == PRE_W || head == ~PRE_W)
		else $error("missing right preamble");

endmodule

bind spdif_frame_bmc_encoder spfe_checker u_spfe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
